// File: hw/rtl/symbol_range_lookup_table_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef SYMBOL_RANGE_LOOKUP_TABLE_MACROS_SVH
`define SYMBOL_RANGE_LOOKUP_TABLE_MACROS_SVH

// Whenever the antecedent holds on a clock edge, the consequent must hold too.
`define SRLT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen on a clock edge outside reset.
`define SRLT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: hw/rtl/srlt_pkg.sv
`timescale 1ns / 1ps

package srlt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_WIDTH  = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int RANGE_W     = 2 * ADDR_WIDTH;

  // Port field widths.
  localparam int OP_W       = 2;
  localparam int TYPE_W     = 4;
  localparam int FIELD_AW   = 64;
  localparam int OUT_IDX_W  = 8;
  localparam int OUT_CNT_W  = 9;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_ZERO = 8'd1;
  localparam logic [MASK_W-1:0]    MASK_RESET    = 16'd98;
  localparam logic                 SKIP_RESET    = 1'b1;

  // Command queue between the front and back halves (depth is a power of two).
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef logic [ADDR_WIDTH-1:0] addr_t;

  // A classified transaction: lo holds the start (load) or the query address.
  typedef struct packed {
    op_e   op;
    logic  pass;
    addr_t lo;
    addr_t hi;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
    logic             full;
  } result_t;

endpackage

// File: hw/rtl/srlt_ram.sv
`timescale 1ns / 1ps

module srlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/srlt_front.sv
`timescale 1ns / 1ps

module srlt_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [srlt_pkg::OP_W-1:0]        op_i,
  input  logic [srlt_pkg::TYPE_W-1:0]      symbol_type_i,
  input  logic [srlt_pkg::FIELD_AW-1:0]    symbol_start_i,
  input  logic [srlt_pkg::FIELD_AW-1:0]    symbol_size_i,
  input  logic [srlt_pkg::FIELD_AW-1:0]    query_address_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [srlt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srlt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  srlt_pkg::q_status_t              q_status_i,
  output logic                             push_o,
  output srlt_pkg::cmd_t                   cmd_o
);

  import srlt_pkg::*;

  logic [MASK_W-1:0]   type_mask_q, type_mask_d;
  logic                skip_zero_q, skip_zero_d;
  addr_t               start_a, size_a, query_a, end_a;
  logic [ADDR_WIDTH:0] sum;
  logic                type_ok, zero_seen;
  op_e                 op;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    type_mask_d = type_mask_q;
    skip_zero_d = skip_zero_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TYPE_MASK: type_mask_d = cfg_data_i[MASK_W-1:0];
        REG_SKIP_ZERO: skip_zero_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_mask_q <= MASK_RESET;
      skip_zero_q <= SKIP_RESET;
    end else begin
      type_mask_q <= type_mask_d;
      skip_zero_q <= skip_zero_d;
    end
  end

  // Addresses are taken modulo the table's address width.
  assign start_a = symbol_start_i[ADDR_WIDTH-1:0];
  assign size_a  = symbol_size_i[ADDR_WIDTH-1:0];
  assign query_a = query_address_i[ADDR_WIDTH-1:0];

  // The end of a range saturates at the top address when the sum carries out.
  assign sum   = {1'b0, start_a} + {1'b0, size_a};
  assign end_a = sum[ADDR_WIDTH] ? '1 : sum[ADDR_WIDTH-1:0];

  // Type filter and zero filter decide whether a load is stored at all.
  assign type_ok   = type_mask_q[symbol_type_i];
  assign zero_seen = (start_a == '0) || (size_a == '0);

  assign op        = op_e'(op_i);
  assign cmd_o.op   = op;
  assign cmd_o.pass = type_ok && !(skip_zero_q && zero_seen);
  assign cmd_o.lo   = (op == OP_LOOKUP) ? query_a : start_a;
  assign cmd_o.hi   = end_a;

  // A transaction is taken whenever the queue has room.
  assign busy_o = q_status_i.full;
  assign push_o = start_i && !q_status_i.full;

endmodule

// File: hw/rtl/srlt_cmd_fifo.sv
`timescale 1ns / 1ps

module srlt_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  srlt_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output srlt_pkg::cmd_t      cmd_o,
  output srlt_pkg::q_status_t status_o
);

  import srlt_pkg::*;

  cmd_t                  entries_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign status_o.full  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;

  assign cmd_o = entries_q[rd_ptr_q];

  // Entry storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CMDQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CMDQ_CNT_W'(1);
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/srlt_back.sv
`timescale 1ns / 1ps

module srlt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srlt_pkg::q_status_t q_status_i,
  input  srlt_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                done_o,
  output srlt_pkg::result_t   result_o
);

  import srlt_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [IDX_W-1:0] chk_q, chk_d;
  logic             chk_valid_q, chk_valid_d;
  addr_t            addr_q, addr_d;
  logic             done_q, done_d;
  result_t          res_q, res_d;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [RANGE_W-1:0] ram_wdata, ram_rdata;
  addr_t              range_lo, range_hi;
  logic               match, last;

  // Start and end of each range share one memory word.
  srlt_ram #(
    .WIDTH(RANGE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_range_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign range_lo = ram_rdata[RANGE_W-1:ADDR_WIDTH];
  assign range_hi = ram_rdata[ADDR_WIDTH-1:0];
  assign match    = (addr_q >= range_lo) && (addr_q < range_hi);
  assign last     = ((CNT_W'(chk_q) + CNT_W'(1)) == count_q);

  assign ram_waddr = count_q[IDX_W-1:0];
  assign ram_wdata = {cmd_i.lo, cmd_i.hi};
  assign ram_raddr = scan_q[IDX_W-1:0];

  // Sequencer: short operations finish straight from the queue head, lookups
  // scan the memory one entry per cycle, each compare in the cycle after its read.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    chk_d       = chk_q;
    chk_valid_d = 1'b0;
    addr_d      = addr_q;
    done_d      = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o      = 1'b1;
          done_d     = 1'b1;
          res_d.hit  = 1'b0;
          res_d.idx  = '0;
          res_d.full = 1'b0;
          unique case (cmd_i.op)
            OP_CLEAR: count_d = '0;
            OP_LOAD: begin
              if (cmd_i.pass) begin
                if (count_q == CNT_W'(TABLE_DEPTH)) begin
                  res_d.full = 1'b1;
                end else begin
                  ram_we    = 1'b1;
                  res_d.hit = 1'b1;
                  res_d.idx = count_q[IDX_W-1:0];
                  count_d   = count_q + CNT_W'(1);
                end
              end
            end
            OP_LOOKUP: begin
              // An empty table misses at once; otherwise start the scan.
              if (count_q != '0) begin
                done_d  = 1'b0;
                state_d = ST_SCAN;
                scan_d  = '0;
                addr_d  = cmd_i.lo;
              end
            end
            OP_NOP: ;
            default: ;
          endcase
          res_d.count = count_d;
        end
      end
      ST_SCAN: begin
        // Issue the next read while entries remain.
        if (scan_q < count_q) begin
          ram_re      = 1'b1;
          chk_valid_d = 1'b1;
          chk_d       = scan_q[IDX_W-1:0];
          scan_d      = scan_q + CNT_W'(1);
        end
        // The first matching entry wins; the last entry ends a miss.
        if (chk_valid_q) begin
          if (match) begin
            done_d      = 1'b1;
            res_d.hit   = 1'b1;
            res_d.idx   = chk_q;
            res_d.count = count_q;
            res_d.full  = 1'b0;
            state_d     = ST_IDLE;
          end else if (last) begin
            done_d      = 1'b1;
            res_d.hit   = 1'b0;
            res_d.idx   = '0;
            res_d.count = count_q;
            res_d.full  = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      chk_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chk_valid_q <= chk_valid_d;
      done_q      <= done_d;
    end
  end

  // Scan pointers, query address and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    chk_q  <= chk_d;
    addr_q <= addr_d;
    res_q  <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: hw/rtl/symbol_range_lookup_table.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// command   start_i / busy_o      op, symbol_type, symbol_start, symbol_size, query_address
// result    done_o (one cycle)    hit, entry_index, entry_count, table_full
// config    cfg_valid_i / _ready  cfg_index_i, cfg_data_i
//
// Clear, load and no-op finish straight from the queue head with a registered result; a
// lookup scans the stored entries one entry per cycle through the range memory's single
// read port. Up to two transactions wait in the command queue; busy_o is high while it
// is full. Reset empties the table through its fill count alone, so no clearing pass
// is needed. Results cannot be held off by the receiver.

module symbol_range_lookup_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [srlt_pkg::OP_W-1:0]        op_i,
  input  logic [srlt_pkg::TYPE_W-1:0]      symbol_type_i,
  input  logic [srlt_pkg::FIELD_AW-1:0]    symbol_start_i,
  input  logic [srlt_pkg::FIELD_AW-1:0]    symbol_size_i,
  input  logic [srlt_pkg::FIELD_AW-1:0]    query_address_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic [srlt_pkg::OUT_IDX_W-1:0]   entry_index_o,
  output logic [srlt_pkg::OUT_CNT_W-1:0]   entry_count_o,
  output logic                             table_full_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [srlt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srlt_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import srlt_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd, head_cmd;
  logic      push, pop;
  result_t   result;

  // Front half: configuration and classification of each transaction.
  srlt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .symbol_type_i  (symbol_type_i),
    .symbol_start_i (symbol_start_i),
    .symbol_size_i  (symbol_size_i),
    .query_address_i(query_address_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  // Command queue decoupling the two halves.
  srlt_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .status_o(q_status)
  );

  // Back half: table storage, fill count and lookup scan.
  srlt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_status_i(q_status),
    .cmd_i     (head_cmd),
    .pop_o     (pop),
    .done_o    (done_o),
    .result_o  (result)
  );

  assign hit_o         = result.hit;
  assign entry_index_o = OUT_IDX_W'(result.idx);
  assign entry_count_o = OUT_CNT_W'(result.count);
  assign table_full_o  = result.full;

endmodule

// File: hw/rtl/srlt_checker.sv
`timescale 1ns / 1ps
`include "symbol_range_lookup_table_macros.svh"

module srlt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             done_o,
  input logic                             hit_o,
  input logic [srlt_pkg::OUT_IDX_W-1:0]   entry_index_o,
  input logic [srlt_pkg::OUT_CNT_W-1:0]   entry_count_o,
  input logic                             table_full_o
);

  import srlt_pkg::*;

  localparam logic [OUT_CNT_W-1:0] FULL_CNT = OUT_CNT_W'(TABLE_DEPTH);

  logic miss_seen, idx_zero, drop_seen, drop_ok, hit_seen, hit_ok, count_high;

  // Conditions on each result, kept short for the assertions below.
  assign miss_seen  = done_o && !hit_o;
  assign idx_zero   = (entry_index_o == '0);
  assign drop_seen  = done_o && table_full_o;
  assign drop_ok    = !hit_o && (entry_count_o == FULL_CNT);
  assign hit_seen   = done_o && hit_o;
  assign hit_ok     = ({1'b0, entry_index_o} < entry_count_o);
  assign count_high = done_o && (entry_count_o > FULL_CNT);

  // A result without a hit reports index zero.
  `SRLT_ASSERT_IMP(a_miss_index_zero, clk_i, rst_ni, miss_seen, idx_zero, "miss with index")

  // A dropped load happens only with the table at capacity and never hits.
  `SRLT_ASSERT_IMP(a_full_drop, clk_i, rst_ni, drop_seen, drop_ok, "full flag out of place")

  // A hit always names an entry below the fill count.
  `SRLT_ASSERT_IMP(a_hit_in_table, clk_i, rst_ni, hit_seen, hit_ok, "hit beyond fill count")

  // The fill count never passes the table depth.
  `SRLT_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_high, "fill count too large")

endmodule

bind symbol_range_lookup_table srlt_checker u_srlt_checker (.*);
